FILE: hdl/hcbd_pkg.sv
// Shared types and character constants for the chunked body decoder.
package hcbd_pkg;

  // Decoder phase, one-hot
  typedef enum logic [4:0] {
    PH_SIZE  = 5'b00001,
    PH_DATA  = 5'b00010,
    PH_SKIP1 = 5'b00100,
    PH_SKIP2 = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  // Hex size parser step, one-hot
  typedef enum logic [5:0] {
    HX_WS     = 6'b000001,
    HX_SIGN   = 6'b000010,
    HX_ZERO   = 6'b000100,
    HX_PREFIX = 6'b001000,
    HX_DIGITS = 6'b010000,
    HX_STOP   = 6'b100000
  } hex_step_t;

  // Status reported with the final word
  typedef enum logic [1:0] {
    ST_ZERO_CHUNK = 2'd0,
    ST_NO_END     = 2'd1,
    ST_TRUNCATED  = 2'd2
  } end_status_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // Whitespace as strtoul sees it: space, HT, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF_HX)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LF_HX)) begin
      v = c - CH_LA + 8'd10;
    end else begin
      v = c - CH_UA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

FILE: hdl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked transfer decoder: one body word in, at most one result word out.
//
//  Channel | Ports                                   | Contents
//  --------+-----------------------------------------+------------------------------------
//  input   | in_tvalid, in_tready, in_tdata, in_tlast | raw body byte; tlast = final byte
//  output  | out_tvalid, out_tready, out_tdata,       | data byte + chunk number;
//          | out_tuser, out_tlast                    | tuser = valid flag + end status
//
// One word per cycle while the output does not stall: the decode of a word (size line
// parse, data count, skip) is a single combinational pass from the decoder state and
// the incoming byte into the result register; out_tvalid rises in the cycle after acceptance.
// Reset (rst_n low, synchronous) returns the decoder to the start of a size line;
// the final word of a body does the same, so the next word starts a new body.
// Input is taken whenever the result register is empty or is being drained, so
// an output stall holds exactly one result and backpressures the input.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS      = 32,
  parameter int CHUNK_NUM_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input word
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] body_byte
  input  logic                   in_tlast,   // is_final
  // result word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((8 + CHUNK_NUM_BITS + 7) / 8) * 8 - 1:0]
                                 out_tdata,  // [7:0] payload_byte, then chunk_number
  output logic [2:0]             out_tuser,  // [0] payload_valid, [2:1] end_status
  output logic                   out_tlast   // body_end
);

  localparam int TDATA_W = ((8 + CHUNK_NUM_BITS + 7) / 8) * 8;

  // Decoder state
  hcbd_pkg::phase_t             phase_r, phase_nxt;
  hcbd_pkg::hex_step_t          step_r, step_nxt;
  logic [SIZE_BITS-1:0]         accum_r, accum_nxt;
  logic                         neg_r, neg_nxt;
  logic                         cr_r, cr_nxt;
  logic [SIZE_BITS-1:0]         left_r, left_nxt;
  logic [CHUNK_NUM_BITS-1:0]    chunk_r, chunk_nxt;

  // Result register
  logic                         ovalid_r, ovalid_nxt;
  logic [7:0]                   obyte_r, obyte_nxt;
  logic                         opv_r, opv_nxt;
  logic [CHUNK_NUM_BITS-1:0]    onum_r, onum_nxt;
  logic                         olast_r, olast_nxt;
  hcbd_pkg::end_status_t        ostat_r, ostat_nxt;

  logic                         accept;
  logic [7:0]                   b;
  hcbd_pkg::hex_step_t          step_a;
  logic                         feed_b;
  logic                         line_end;
  logic [SIZE_BITS-1:0]         line_size;
  logic                         data;
  hcbd_pkg::phase_t             phase_d;
  logic                         fin;

  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign fin       = in_tlast;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = TDATA_W'({onum_r, obyte_r});
  assign out_tuser  = {ostat_r, opv_r};
  assign out_tlast  = olast_r;

  // Size line decode and data counting for the current word.
  always_comb begin
    step_a    = step_r;
    feed_b    = 1'b0;
    line_end  = 1'b0;
    line_size = accum_r;
    data      = 1'b0;
    phase_d   = phase_r;
    step_nxt  = step_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    cr_nxt    = cr_r;
    left_nxt  = left_r;
    chunk_nxt = chunk_r;

    unique case (phase_r)
      hcbd_pkg::PH_SIZE: begin
        if (cr_r && (b == hcbd_pkg::CH_LF)) begin
          line_end = 1'b1;
        end else begin
          // A pending CR without LF is whitespace to the parser
          if (cr_r) begin
            step_a = (step_r == hcbd_pkg::HX_WS) ? hcbd_pkg::HX_WS : hcbd_pkg::HX_STOP;
          end
          cr_nxt   = (b == hcbd_pkg::CH_CR);
          feed_b   = (b != hcbd_pkg::CH_CR);
          step_nxt = step_a;
        end

        if (feed_b) begin
          priority if (step_a == hcbd_pkg::HX_WS && hcbd_pkg::is_ws(b)) begin
            step_nxt = hcbd_pkg::HX_WS;
          end else if (step_a == hcbd_pkg::HX_WS && b == hcbd_pkg::CH_PLUS) begin
            step_nxt = hcbd_pkg::HX_SIGN;
          end else if (step_a == hcbd_pkg::HX_WS && b == hcbd_pkg::CH_MINUS) begin
            step_nxt = hcbd_pkg::HX_SIGN;
            neg_nxt  = 1'b1;
          end else if (step_a == hcbd_pkg::HX_WS || step_a == hcbd_pkg::HX_SIGN) begin
            if (b == hcbd_pkg::CH_0) begin
              step_nxt = hcbd_pkg::HX_ZERO;
            end else if (hcbd_pkg::is_hex(b)) begin
              accum_nxt = SIZE_BITS'(hcbd_pkg::hex_val(b));
              step_nxt  = hcbd_pkg::HX_DIGITS;
            end else begin
              step_nxt = hcbd_pkg::HX_STOP;
            end
          end else if (step_a == hcbd_pkg::HX_ZERO &&
                       (b == hcbd_pkg::CH_LX || b == hcbd_pkg::CH_UX)) begin
            step_nxt = hcbd_pkg::HX_PREFIX;
          end else if (step_a == hcbd_pkg::HX_ZERO || step_a == hcbd_pkg::HX_PREFIX ||
                       step_a == hcbd_pkg::HX_DIGITS) begin
            if (hcbd_pkg::is_hex(b)) begin
              // Saturate once the top nibble would be shifted out
              if (accum_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                accum_nxt = '1;
              end else begin
                accum_nxt = {accum_r[SIZE_BITS-5:0], hcbd_pkg::hex_val(b)};
              end
              step_nxt = hcbd_pkg::HX_DIGITS;
            end else begin
              step_nxt = hcbd_pkg::HX_STOP;
            end
          end else begin
            step_nxt = step_a;
          end
        end

        if (line_end) begin
          line_size = (neg_r && (accum_r != '0)) ? '1 : accum_r;
          cr_nxt    = 1'b0;
          step_nxt  = hcbd_pkg::HX_WS;
          accum_nxt = '0;
          neg_nxt   = 1'b0;
          if (line_size == '0) begin
            phase_d = hcbd_pkg::PH_DONE;
          end else begin
            left_nxt = line_size;
            phase_d  = hcbd_pkg::PH_DATA;
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        data     = 1'b1;
        left_nxt = left_r - SIZE_BITS'(1);
        if (left_r == SIZE_BITS'(1)) begin
          phase_d = hcbd_pkg::PH_SKIP1;
        end
      end
      hcbd_pkg::PH_SKIP1: begin
        phase_d = hcbd_pkg::PH_SKIP2;
      end
      hcbd_pkg::PH_SKIP2: begin
        chunk_nxt = chunk_r + CHUNK_NUM_BITS'(1);
        phase_d   = hcbd_pkg::PH_SIZE;
      end
      hcbd_pkg::PH_DONE: begin
        phase_d = hcbd_pkg::PH_DONE;
      end
      default: begin
        phase_d = hcbd_pkg::PH_DONE;
      end
    endcase

    phase_nxt = phase_d;
    // Final word: start a fresh body on the next word
    if (fin) begin
      phase_nxt = hcbd_pkg::PH_SIZE;
      step_nxt  = hcbd_pkg::HX_WS;
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      cr_nxt    = 1'b0;
      left_nxt  = '0;
      chunk_nxt = '0;
    end
  end

  // Result word
  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    opv_nxt    = opv_r;
    onum_nxt   = onum_r;
    olast_nxt  = olast_r;
    ostat_nxt  = ostat_r;
    if (accept && (data || fin)) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = data ? b : 8'd0;
      opv_nxt    = data;
      onum_nxt   = data ? chunk_r : '0;
      olast_nxt  = fin;
      priority if (!fin) begin
        ostat_nxt = hcbd_pkg::ST_ZERO_CHUNK;
      end else if (phase_d == hcbd_pkg::PH_DONE) begin
        ostat_nxt = hcbd_pkg::ST_ZERO_CHUNK;
      end else if (data && (left_r != SIZE_BITS'(1))) begin
        ostat_nxt = hcbd_pkg::ST_TRUNCATED;
      end else begin
        ostat_nxt = hcbd_pkg::ST_NO_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hcbd_pkg::PH_SIZE;
      step_r   <= hcbd_pkg::HX_WS;
      accum_r  <= '0;
      neg_r    <= 1'b0;
      cr_r     <= 1'b0;
      left_r   <= '0;
      chunk_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        step_r  <= step_nxt;
        accum_r <= accum_nxt;
        neg_r   <= neg_nxt;
        cr_r    <= cr_nxt;
        left_r  <= left_nxt;
        chunk_r <= chunk_nxt;
      end
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    opv_r   <= opv_nxt;
    onum_r  <= onum_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
  end

endmodule
